// ----- hw/rtl/c8pf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-8 packet framer package
// Shared types, constants and the CRC-8 byte update (poly 0x07, MSB first).
// ----------------------------------------------------------------------------
package c8pf_pkg;

   // Byte and result-slot types.
   typedef logic [7:0] byte_type;
   localparam int unsigned SLOT_COUNT = 4;
   localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
   typedef logic [SLOT_W-1:0] slot_type;

   // Item mode codes.
   localparam logic MODE_HEADER  = 1'b0;
   localparam logic MODE_PAYLOAD = 1'b1;

   // Result slot positions.
   localparam slot_type SLOT_FIRST  = 2'd0;
   localparam slot_type SLOT_SECOND = 2'd1;
   localparam slot_type SLOT_THIRD  = 2'd2;
   localparam slot_type SLOT_FOURTH = 2'd3;

   // CRC constants and the start byte after reset.
   localparam byte_type CRC_POLY    = 8'h07;
   localparam byte_type CRC_TOPBIT  = 8'h80;
   localparam byte_type START_RESET = 8'hAA;

   // Eight shift steps of the CRC register for one byte that is already
   // folded into it; synthesis reduces this to an XOR network.
   function automatic byte_type crc8_byte(input byte_type value);
      byte_type c;
      c = value;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOPBIT) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/crc8_packet_framer.sv -----
`default_nettype none
// The first result of an item passes through the result slot buffer and then the output register.
// Throughput: one result per cycle unless rsp_ready stalls the output; a payload item that
// yields one result is taken every cycle, a header holds the input while its three
// or four bytes drain from the result slot buffer one per cycle.
// Reset (synchronous, active high) closes any open frame, clears the CRC and
// empties both stages; the start byte returns to 0xAA.
// ----------------------------------------------------------------------------
// CRC-8 packet framer
// Turns header and payload items into framed bytes ending in a CRC-8/SMBUS.
// ----------------------------------------------------------------------------
module crc8_packet_framer (
   input  wire logic       clock,
   input  wire logic       reset,
   // Configuration write channel.
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_start_byte,
   // Input item channel.
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_mode,
   input  wire logic [7:0] req_command,
   input  wire logic [7:0] req_payload_length,
   input  wire logic [7:0] req_payload_byte,
   // Result item channel.
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_crc,
   output logic            rsp_run_last
);

   // Configuration and frame state.
   c8pf_pkg::byte_type start_ff, start_in;
   c8pf_pkg::byte_type crc_ff, crc_in;
   c8pf_pkg::byte_type left_ff, left_in;
   logic               in_frame_ff, in_frame_in;

   // Result slot buffer filled by one accepted item.
   logic               buf_valid_ff, buf_valid_in;
   c8pf_pkg::byte_type buf_byte_ff [c8pf_pkg::SLOT_COUNT];
   c8pf_pkg::byte_type buf_byte_in [c8pf_pkg::SLOT_COUNT];
   c8pf_pkg::slot_type buf_last_ff, buf_last_in;
   c8pf_pkg::slot_type buf_idx_ff, buf_idx_in;
   logic               buf_crc_ff, buf_crc_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   c8pf_pkg::byte_type rsp_byte_ff, rsp_byte_in;
   logic               rsp_crc_ff, rsp_crc_in;
   logic               rsp_last_ff, rsp_last_in;

   // Handshake and item decode.
   logic               out_free, buf_move, buf_done, accept, load;
   c8pf_pkg::byte_type hdr_crc, pay_crc, left_dec;

   // Handshake: the buffer takes a new item once its last byte moves out.
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign buf_move  = buf_valid_ff && out_free;
   assign buf_done  = buf_move && (buf_idx_ff == buf_last_ff);
   assign req_ready = !buf_valid_ff || buf_done;
   assign accept    = req_valid && req_ready;

   // CRC terms for a header and for a payload byte.
   assign hdr_crc  = c8pf_pkg::crc8_byte(c8pf_pkg::crc8_byte(req_command) ^ req_payload_length);
   assign pay_crc  = c8pf_pkg::crc8_byte(crc_ff ^ req_payload_byte);
   assign left_dec = left_ff - 8'd1;

   // Item processing: frame state update and result slot contents.
   always_comb begin
      start_in    = start_ff;
      crc_in      = crc_ff;
      left_in     = left_ff;
      in_frame_in = in_frame_ff;
      load        = 1'b0;
      buf_last_in = c8pf_pkg::SLOT_FIRST;
      buf_crc_in  = 1'b0;
      for (int k = 0; k < c8pf_pkg::SLOT_COUNT; k++) begin
         buf_byte_in[k] = buf_byte_ff[k];
      end
      if (csr_valid && csr_ready) begin
         start_in = csr_start_byte;
      end
      if (accept) begin
         if (req_mode == c8pf_pkg::MODE_HEADER) begin
            // A header opens a fresh frame, abandoning any open one.
            load        = 1'b1;
            crc_in      = hdr_crc;
            left_in     = req_payload_length;
            in_frame_in = (req_payload_length != 8'd0);
            buf_byte_in[c8pf_pkg::SLOT_FIRST]  = start_ff;
            buf_byte_in[c8pf_pkg::SLOT_SECOND] = req_command;
            buf_byte_in[c8pf_pkg::SLOT_THIRD]  = req_payload_length;
            buf_byte_in[c8pf_pkg::SLOT_FOURTH] = hdr_crc;
            buf_crc_in  = (req_payload_length == 8'd0);
            buf_last_in = buf_crc_in ? c8pf_pkg::SLOT_FOURTH : c8pf_pkg::SLOT_THIRD;
         end else if (in_frame_ff && left_ff != 8'd0) begin
            // A payload byte inside a frame passes through; the last one adds the CRC.
            load        = 1'b1;
            crc_in      = pay_crc;
            left_in     = left_dec;
            in_frame_in = (left_dec != 8'd0);
            buf_byte_in[c8pf_pkg::SLOT_FIRST]  = req_payload_byte;
            buf_byte_in[c8pf_pkg::SLOT_SECOND] = pay_crc;
            buf_crc_in  = (left_dec == 8'd0);
            buf_last_in = buf_crc_in ? c8pf_pkg::SLOT_SECOND : c8pf_pkg::SLOT_FIRST;
         end else begin
            // A payload byte outside a frame is dropped.
            in_frame_in = 1'b0;
         end
      end
   end

   // Slot buffer control.
   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_idx_in   = buf_idx_ff;
      if (load) begin
         buf_valid_in = 1'b1;
         buf_idx_in   = c8pf_pkg::SLOT_FIRST;
      end else if (buf_done) begin
         buf_valid_in = 1'b0;
      end else if (buf_move) begin
         buf_idx_in = buf_idx_ff + 2'd1;
      end
   end

   // Output register load from the current slot.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_crc_in   = rsp_crc_ff;
      rsp_last_in  = rsp_last_ff;
      if (buf_move) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = buf_byte_ff[buf_idx_ff];
         rsp_last_in  = (buf_idx_ff == buf_last_ff);
         rsp_crc_in   = buf_crc_ff && (buf_idx_ff == buf_last_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= c8pf_pkg::START_RESET;
         crc_ff       <= 8'd0;
         left_ff      <= 8'd0;
         in_frame_ff  <= 1'b0;
         buf_valid_ff <= 1'b0;
         buf_idx_ff   <= c8pf_pkg::SLOT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         crc_ff       <= crc_in;
         left_ff      <= left_in;
         in_frame_ff  <= in_frame_in;
         buf_valid_ff <= buf_valid_in;
         buf_idx_ff   <= buf_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int k = 0; k < c8pf_pkg::SLOT_COUNT; k++) begin
         buf_byte_ff[k] <= buf_byte_in[k];
      end
      if (load) begin
         buf_last_ff <= buf_last_in;
         buf_crc_ff  <= buf_crc_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_crc_ff  <= rsp_crc_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_is_crc   = rsp_crc_ff;
   assign rsp_run_last = rsp_last_ff;

   // An open frame always expects at least one more payload byte.
   a_frame_count: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (left_ff != 8'd0))
      else $error("open frame with zero bytes left");

   // The slot index never passes the last slot of the item.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (buf_idx_ff <= buf_last_ff))
      else $error("slot index beyond last slot");

   // A CRC byte always closes the results of its item.
   a_crc_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_crc_ff) |-> rsp_last_ff)
      else $error("CRC byte not marked last");

   // The final payload byte of a frame closes it.
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == c8pf_pkg::MODE_PAYLOAD && in_frame_ff && left_ff == 8'd1)
      |=> !in_frame_ff)
      else $error("frame stayed open after its last byte");

endmodule
`default_nettype wire
